// ----- hdl/grid_dda_raycaster_defines.svh -----
// ---------------------------------------------------------------------------
// Grid DDA raycaster assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef GRID_DDA_RAYCASTER_DEFINES_SVH
`define GRID_DDA_RAYCASTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define GDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define GDR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/gdr_pkg.sv -----
// ---------------------------------------------------------------------------
// gdr_pkg
// Types, operation codes and constants shared by the raycaster modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 22;

  // Camera plane scale 0.57735 in Q0.14.
  localparam int PLANE_K = 9459;
  localparam logic [40:0] DELTA_ZERO = 41'h100_0000_0000;
  localparam logic [23:0] DIST_MAX   = 24'hFF_FFFF;
  localparam logic [23:0] DIST_MIN   = 24'd7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_H   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd6;

  // Datapath operations issued by the controller, one per cycle.
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_CLEAR      = 5'd1;
  localparam logic [4:0] OP_CELL       = 5'd2;
  localparam logic [4:0] OP_ACCEPT     = 5'd3;
  localparam logic [4:0] OP_PLANE_Y    = 5'd4;
  localparam logic [4:0] OP_CAM_START  = 5'd5;
  localparam logic [4:0] OP_RAY_X      = 5'd6;
  localparam logic [4:0] OP_RAY_Y      = 5'd7;
  localparam logic [4:0] OP_DX_START   = 5'd8;
  localparam logic [4:0] OP_DY_START   = 5'd9;
  localparam logic [4:0] OP_SX_LO      = 5'd10;
  localparam logic [4:0] OP_SX_HI      = 5'd11;
  localparam logic [4:0] OP_SY_LO      = 5'd12;
  localparam logic [4:0] OP_SY_HI      = 5'd13;
  localparam logic [4:0] OP_WALK_INIT  = 5'd14;
  localparam logic [4:0] OP_STEP       = 5'd15;
  localparam logic [4:0] OP_PERP_START = 5'd16;
  localparam logic [4:0] OP_PERP_DONE  = 5'd17;
  localparam logic [4:0] OP_WALL_MUL   = 5'd18;
  localparam logic [4:0] OP_WALL_SUM   = 5'd19;
  localparam logic [4:0] OP_EMIT_HIT   = 5'd20;
  localparam logic [4:0] OP_EMIT_MISS  = 5'd21;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic clear_last;
    logic step_out;
    logic map_wall;
    logic step_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/gdr_divider.sv -----
// ---------------------------------------------------------------------------
// gdr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_divider #(
  parameter int NW = 41,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quot
);

  localparam int CNW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, den_r;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNW'(NW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

// ----- hdl/gdr_datapath.sv -----
// ---------------------------------------------------------------------------
// gdr_datapath
// Configuration registers, map memory, shared multiplier and divider, DDA walk.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_datapath import gdr_pkg::*; #(
  parameter int GRID_DIM = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  input  wire logic                   cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int DEPTH      = GRID_DIM * GRID_DIM;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(GRID_DIM + 64) + 2;
  localparam int STEP_LIMIT = 2 * (GRID_DIM + 64) + 4;
  localparam int SCW        = $clog2(STEP_LIMIT + 1);
  localparam int NMW        = CW + 17;
  localparam int DNW        = CW + 33;
  localparam int SDW        = 42 + SCW;

  // Configuration.
  logic [21:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r;
  logic [6:0]         grid_w_r, grid_h_r;
  logic [12:0]        scr_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      dir_x_r  <= 16'sd16384;
      dir_y_r  <= '0;
      grid_w_r <= 7'd64;
      grid_h_r <= 7'd64;
      scr_w_r  <= 13'd640;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_POS_X:    pos_x_r  <= cfg_data[21:0];
        CFG_POS_Y:    pos_y_r  <= cfg_data[21:0];
        CFG_DIR_X:    dir_x_r  <= $signed(cfg_data[15:0]);
        CFG_DIR_Y:    dir_y_r  <= $signed(cfg_data[15:0]);
        CFG_GRID_W:   grid_w_r <= cfg_data[6:0];
        CFG_GRID_H:   grid_h_r <= cfg_data[6:0];
        CFG_SCREEN_W: scr_w_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  logic [11:0]          column_r;
  logic signed [15:0]   plane_x_r, plane_y_r;
  logic signed [30:0]   cam_r;
  logic signed [31:0]   ray_x_r, ray_y_r;
  logic [40:0]          dx_r, dy_r;
  logic [24:0]          acc_r;
  logic [SDW-1:0]       side_x_r, side_y_r;
  logic signed [CW-1:0] mx_r, my_r;
  logic                 side_r;
  logic [SCW-1:0]       cnt_r;
  logic                 num_neg_r, num_zero_r, ray_neg_r, ray_zero_r;
  logic signed [24:0]   perp_r;
  logic [15:0]          frac_r;
  logic signed [65:0]   prod_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [AW-1:0]        clr_r;
  logic                 map_q_r;
  logic                 map_mem [DEPTH];

  // Shared divider.
  logic           div_start;
  logic [DNW-1:0] div_num;
  logic [31:0]    div_den;
  logic           div_busy;
  logic [DNW-1:0] div_q;

  gdr_divider #(.NW(DNW), .DW(32)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_q)
  );

  // Combinational helpers.
  logic [12:0]          scr_w_eff;
  logic signed [30:0]   cam_val;
  logic [31:0]          abs_rx, abs_ry;
  logic [16:0]          fx_sel, fy_sel;
  logic signed [32:0]   mul_a, mul_b;
  logic                 take_x;
  logic signed [CW-1:0] mx_nxt, my_nxt;
  logic [SDW-1:0]       side_x_nxt, side_y_nxt;
  logic [CW-1:0]        gw_c, gh_c;
  logic                 step_out;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 cell_in_range, mem_we, mem_bit;
  logic signed [NMW-1:0] axis_m, axis_pos, num_val;
  logic [NMW-1:0]       num_abs;
  logic                 axis_neg;
  logic [31:0]          axis_den;
  logic [23:0]          q_sat;
  logic                 perp_neg;
  logic [31:0]          wall_lo;
  logic [23:0]          dist_val;
  logic [SDW-1:0]       side_new;

  always_comb begin
    scr_w_eff = (scr_w_r == '0) ? 13'd1 : scr_w_r;
    cam_val   = $signed(div_q[30:0]) - 31'sd65536;
    abs_rx    = ray_x_r[31] ? 32'(-ray_x_r) : 32'(ray_x_r);
    abs_ry    = ray_y_r[31] ? 32'(-ray_y_r) : 32'(ray_y_r);
    fx_sel    = ray_x_r[31] ? {1'b0, pos_x_r[15:0]} : 17'h10000 - {1'b0, pos_x_r[15:0]};
    fy_sel    = ray_y_r[31] ? {1'b0, pos_y_r[15:0]} : 17'h10000 - {1'b0, pos_y_r[15:0]};
    side_new  = SDW'(acc_r) + (SDW'(prod_r[33:0]) << 8);

    // One DDA step: advance whichever side distance is shorter; a tie advances y.
    take_x     = side_x_r < side_y_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    side_x_nxt = side_x_r;
    side_y_nxt = side_y_r;
    if (take_x) begin
      mx_nxt     = ray_x_r[31] ? mx_r - CW'(1) : mx_r + CW'(1);
      side_x_nxt = side_x_r + SDW'(dx_r);
    end else begin
      my_nxt     = ray_y_r[31] ? my_r - CW'(1) : my_r + CW'(1);
      side_y_nxt = side_y_r + SDW'(dy_r);
    end
    gw_c = (CW'(grid_w_r) > CW'(GRID_DIM)) ? CW'(GRID_DIM) : CW'(grid_w_r);
    gh_c = (CW'(grid_h_r) > CW'(GRID_DIM)) ? CW'(GRID_DIM) : CW'(grid_h_r);
    step_out = mx_nxt[CW-1] | my_nxt[CW-1] | (mx_nxt >= $signed(gw_c)) |
               (my_nxt >= $signed(gh_c));
    rd_addr  = AW'(AW'(my_nxt) * AW'(GRID_DIM) + AW'(mx_nxt));

    // Map writes: clearing sweep or a cell item.
    cell_in_range = (int'(in_tdata[5:0]) < GRID_DIM) && (int'(in_tdata[11:6]) < GRID_DIM);
    if (cmd.op == OP_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_r;
      mem_bit = 1'b0;
    end else begin
      mem_we  = (cmd.op == OP_CELL) && cell_in_range;
      wr_addr = AW'(AW'(in_tdata[11:6]) * AW'(GRID_DIM) + AW'(in_tdata[5:0]));
      mem_bit = in_tdata[12];
    end

    // Distance numerator along the axis of the hit face.
    axis_m   = side_r ? NMW'(my_r) : NMW'(mx_r);
    axis_pos = side_r ? $signed(NMW'(pos_y_r)) : $signed(NMW'(pos_x_r));
    axis_neg = side_r ? ray_y_r[31] : ray_x_r[31];
    axis_den = side_r ? abs_ry : abs_rx;
    num_val  = (axis_m <<< 16) - axis_pos + (axis_neg ? NMW'(65536) : NMW'(0));
    num_abs  = num_val[NMW-1] ? NMW'(-num_val) : NMW'(num_val);

    q_sat    = (ray_zero_r || (div_q > DNW'(DIST_MAX))) ? DIST_MAX : div_q[23:0];
    perp_neg = (num_neg_r != ray_neg_r) && !num_zero_r;
    wall_lo  = {(side_r ? pos_x_r[15:0] : pos_y_r[15:0]), 16'h0000} + prod_r[31:0];
    dist_val = (perp_r <= $signed({1'b0, DIST_MIN})) ? DIST_MIN : perp_r[23:0];

    // Multiplier and divider operands.
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      OP_ACCEPT: begin
        mul_a = -33'(dir_y_r);
        mul_b = 33'(PLANE_K);
      end
      OP_PLANE_Y: begin
        mul_a = 33'(dir_x_r);
        mul_b = 33'(PLANE_K);
      end
      OP_CAM_START: begin
        div_start = 1'b1;
        div_num   = DNW'({column_r, 17'h00000});
        div_den   = 32'(scr_w_eff);
      end
      OP_RAY_X: begin
        mul_a = 33'(plane_x_r);
        mul_b = 33'(cam_val);
      end
      OP_RAY_Y: begin
        mul_a = 33'(plane_y_r);
        mul_b = 33'(cam_r);
      end
      OP_DX_START: begin
        div_start = 1'b1;
        div_num   = DNW'(33'h1_0000_0000);
        div_den   = abs_rx;
      end
      OP_DY_START: begin
        div_start = 1'b1;
        div_num   = DNW'(33'h1_0000_0000);
        div_den   = abs_ry;
      end
      OP_SX_LO: begin
        mul_a = $signed(33'(fx_sel));
        mul_b = $signed(33'(dx_r[23:0]));
      end
      OP_SX_HI: begin
        mul_a = $signed(33'(fx_sel));
        mul_b = $signed(33'(dx_r[40:24]));
      end
      OP_SY_LO: begin
        mul_a = $signed(33'(fy_sel));
        mul_b = $signed(33'(dy_r[23:0]));
      end
      OP_SY_HI: begin
        mul_a = $signed(33'(fy_sel));
        mul_b = $signed(33'(dy_r[40:24]));
      end
      OP_PERP_START: begin
        div_start = 1'b1;
        div_num   = DNW'(num_abs) << 16;
        div_den   = axis_den;
      end
      OP_WALL_MUL: begin
        mul_a = 33'(perp_r);
        mul_b = side_r ? 33'(ray_x_r) : 33'(ray_y_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= mem_bit;
    end
    map_q_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      OP_ACCEPT:    column_r  <= in_tdata[24:13];
      OP_PLANE_Y:   plane_x_r <= 16'(prod_r >>> 14);
      OP_CAM_START: plane_y_r <= 16'(prod_r >>> 14);
      OP_RAY_X:     cam_r     <= cam_val;
      OP_RAY_Y:     ray_x_r   <= 32'(prod_r >>> 14) + {{14{dir_x_r[15]}}, dir_x_r, 2'b00};
      OP_DX_START:  ray_y_r   <= 32'(prod_r >>> 14) + {{14{dir_y_r[15]}}, dir_y_r, 2'b00};
      OP_DY_START:  dx_r      <= (ray_x_r == '0) ? DELTA_ZERO : 41'(div_q);
      OP_SX_LO:     dy_r      <= (ray_y_r == '0) ? DELTA_ZERO : 41'(div_q);
      OP_SX_HI:     acc_r     <= prod_r[40:16];
      OP_SY_LO:     side_x_r  <= side_new;
      OP_SY_HI:     acc_r     <= prod_r[40:16];
      OP_WALK_INIT: begin
        side_y_r <= side_new;
        mx_r     <= $signed(CW'(pos_x_r[21:16]));
        my_r     <= $signed(CW'(pos_y_r[21:16]));
        cnt_r    <= '0;
      end
      OP_STEP: begin
        mx_r     <= mx_nxt;
        my_r     <= my_nxt;
        side_x_r <= side_x_nxt;
        side_y_r <= side_y_nxt;
        side_r   <= !take_x;
        cnt_r    <= cnt_r + 1'b1;
      end
      OP_PERP_START: begin
        num_neg_r  <= num_val[NMW-1];
        num_zero_r <= (num_val == '0);
        ray_neg_r  <= axis_neg;
        ray_zero_r <= (axis_den == '0);
      end
      OP_PERP_DONE: perp_r <= perp_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      OP_WALL_SUM:  frac_r <= wall_lo[31:16];
      OP_EMIT_HIT:  out_data_r <= {6'b0, column_r, frac_r, dist_val, my_r[5:0], mx_r[5:0],
                                   side_r, 1'b1};
      OP_EMIT_MISS: out_data_r <= {6'b0, column_r, 54'b0};
      default: ;
    endcase
  end

  assign sts.div_busy   = div_busy;
  assign sts.clear_last = (clr_r == AW'(DEPTH - 1));
  assign sts.step_out   = step_out;
  assign sts.map_wall   = map_q_r;
  assign sts.step_last  = (cnt_r == SCW'(STEP_LIMIT));
  assign out_tdata      = out_data_r;

endmodule

`default_nettype wire

// ----- hdl/gdr_ctrl.sv -----
// ---------------------------------------------------------------------------
// gdr_ctrl
// Sequencer for map clearing, cell writes and the per-column ray cast.
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_dda_raycaster_defines.svh"

module gdr_ctrl import gdr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire logic    in_req_type,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam logic [4:0] S_CLEAR      = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_PLANE_Y    = 5'd2;
  localparam logic [4:0] S_CAM_START  = 5'd3;
  localparam logic [4:0] S_CAM_WAIT   = 5'd4;
  localparam logic [4:0] S_RAY_X      = 5'd5;
  localparam logic [4:0] S_RAY_Y      = 5'd6;
  localparam logic [4:0] S_DX_START   = 5'd7;
  localparam logic [4:0] S_DX_WAIT    = 5'd8;
  localparam logic [4:0] S_DY_START   = 5'd9;
  localparam logic [4:0] S_DY_WAIT    = 5'd10;
  localparam logic [4:0] S_SX_LO      = 5'd11;
  localparam logic [4:0] S_SX_HI      = 5'd12;
  localparam logic [4:0] S_SY_LO      = 5'd13;
  localparam logic [4:0] S_SY_HI      = 5'd14;
  localparam logic [4:0] S_WALK_INIT  = 5'd15;
  localparam logic [4:0] S_STEP       = 5'd16;
  localparam logic [4:0] S_CHECK      = 5'd17;
  localparam logic [4:0] S_PERP_START = 5'd18;
  localparam logic [4:0] S_PERP_WAIT  = 5'd19;
  localparam logic [4:0] S_PERP_DONE  = 5'd20;
  localparam logic [4:0] S_WALL_MUL   = 5'd21;
  localparam logic [4:0] S_WALL_SUM   = 5'd22;
  localparam logic [4:0] S_EMIT       = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic       hit_r, hit_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_req_type) begin
            cmd.op    = OP_ACCEPT;
            state_nxt = S_PLANE_Y;
          end else begin
            cmd.op = OP_CELL;
          end
        end
      end
      S_PLANE_Y: begin
        cmd.op    = OP_PLANE_Y;
        state_nxt = S_CAM_START;
      end
      S_CAM_START: begin
        cmd.op    = OP_CAM_START;
        state_nxt = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_RAY_X;
        end
      end
      S_RAY_X: begin
        cmd.op    = OP_RAY_X;
        state_nxt = S_RAY_Y;
      end
      S_RAY_Y: begin
        cmd.op    = OP_RAY_Y;
        state_nxt = S_DX_START;
      end
      S_DX_START: begin
        cmd.op    = OP_DX_START;
        state_nxt = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_DY_START;
        end
      end
      S_DY_START: begin
        cmd.op    = OP_DY_START;
        state_nxt = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_SX_LO;
        end
      end
      S_SX_LO: begin
        cmd.op    = OP_SX_LO;
        state_nxt = S_SX_HI;
      end
      S_SX_HI: begin
        cmd.op    = OP_SX_HI;
        state_nxt = S_SY_LO;
      end
      S_SY_LO: begin
        cmd.op    = OP_SY_LO;
        state_nxt = S_SY_HI;
      end
      S_SY_HI: begin
        cmd.op    = OP_SY_HI;
        state_nxt = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        cmd.op    = OP_WALK_INIT;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (sts.step_out) begin
          hit_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.map_wall) begin
          state_nxt = S_PERP_START;
        end else if (sts.step_last) begin
          hit_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_PERP_START: begin
        cmd.op    = OP_PERP_START;
        state_nxt = S_PERP_WAIT;
      end
      S_PERP_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_PERP_DONE;
        end
      end
      S_PERP_DONE: begin
        cmd.op    = OP_PERP_DONE;
        state_nxt = S_WALL_MUL;
      end
      S_WALL_MUL: begin
        cmd.op    = OP_WALL_MUL;
        state_nxt = S_WALL_SUM;
      end
      S_WALL_SUM: begin
        cmd.op    = OP_WALL_SUM;
        hit_nxt   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = hit_r ? OP_EMIT_HIT : OP_EMIT_MISS;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `GDR_ASSERT(a_div_start_idle, clk, rst_n, (cmd.op == OP_CAM_START || cmd.op == OP_DX_START || cmd.op == OP_DY_START || cmd.op == OP_PERP_START) |-> !sts.div_busy, "divider started while busy")
  `GDR_ASSERT(a_emit_free, clk, rst_n, (cmd.op == OP_EMIT_HIT || cmd.op == OP_EMIT_MISS) |-> (!out_valid_r || out_tready), "result overwrites an untaken word")
  `GDR_ASSERT(a_step_next, clk, rst_n, (state_r == S_STEP) |=> (state_r == S_CHECK || state_r == S_EMIT), "walk step not followed by check or result")
  `GDR_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> (state_r == S_CLEAR && !out_valid_r), "reset does not start the map clear")

endmodule

`default_nettype wire

// ----- hdl/grid_dda_raycaster.sv -----
// ---------------------------------------------------------------------------
// grid_dda_raycaster
// Wall/open grid map with a per-column camera ray cast by DDA grid walk.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in_      slave      in_tvalid / in_tready   tdata: cell or column, tuser: req_type
//  out_     master     out_tvalid / out_tready tdata: hit, side, cell, distance, frac, column
//  cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// After reset the map is cleared one cell per cycle, all GRID_DIM*GRID_DIM cells
// (4096 at the default), before the first input word is taken.
// A cast's work is mostly 42-bit divisions through one shared bit-serial
// divider (three per cast and a fourth on a hit), plus the grid steps of
// the walk (one map memory read per step).
// One cast is in flight at a time; the output register lets the next word be
// accepted while the previous result waits for out_tready.
// Configuration words are taken in any cycle and should only be sent while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_dda_raycaster import gdr_pkg::*; #(
  parameter int GRID_DIM = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // [5:0] cell_col, [11:6] cell_row, [12] cell_is_wall, [24:13] column
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] req_type: 0 writes a map cell, 1 casts a ray
  input  wire logic [0:0]             in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [0] hit, [1] side, [7:2] hit_col, [13:8] hit_row, [37:14] distance,
  // [53:38] wall_frac, [65:54] out_column, upper bits zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  gdr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser[0]),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .sts         (sts)
  );

  gdr_datapath #(.GRID_DIM(GRID_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
